/* rtl/core/dcs_pkg.sv */
// Package for the defrost cycle sequencer: phase and heating sub-step codes,
// register indexes and the structs shared between the sequencer modules.
// No dependencies.
`default_nettype none

package dcs_pkg;

  localparam logic [1:0] PH_STANDBY = 2'd0;
  localparam logic [1:0] PH_HEAT    = 2'd1;
  localparam logic [1:0] PH_DRIP    = 2'd2;

  localparam logic [2:0] HS_IDLE   = 3'd0;
  localparam logic [2:0] HS_DELAY1 = 3'd1;
  localparam logic [2:0] HS_VALVE  = 3'd2;
  localparam logic [2:0] HS_DELAY2 = 3'd3;
  localparam logic [2:0] HS_COMP   = 3'd4;
  localparam logic [2:0] HS_RAMP   = 3'd5;
  localparam logic [2:0] HS_RUN    = 3'd6;

  localparam logic [2:0] REG_DEFROST_INTERVAL = 3'd0;
  localparam logic [2:0] REG_MIN_INTERVAL     = 3'd1;
  localparam logic [2:0] REG_HEAT_MAX_TIME    = 3'd2;
  localparam logic [2:0] REG_DRIP_TIME        = 3'd3;
  localparam logic [2:0] REG_HEAT_TEMP_LIMIT  = 3'd4;
  localparam logic [2:0] REG_TEMP_DIFF_THRESH = 3'd5;
  localparam logic [2:0] REG_STEP_DELAY       = 3'd6;
  localparam logic [2:0] REG_COMP_WAIT        = 3'd7;

  typedef struct packed {
    logic        [16:0] defrost_interval;
    logic        [16:0] min_interval;
    logic        [11:0] heat_max_time;
    logic        [11:0] drip_time;
    logic signed [10:0] heat_temp_limit;
    logic        [9:0]  temp_diff_threshold;
    logic        [9:0]  step_delay;
    logic        [9:0]  comp_wait;
  } cfg_t;

  typedef struct packed {
    logic [2:0] substep;
    logic [9:0] step_count;
    logic [8:0] ramp_freq;
  } heat_t;

  typedef struct packed {
    logic heater;
    logic comp;
    logic evap_fan;
    logic cond_fan;
  } lat_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [2:0] heat_step;
    logic       heater_on;
    logic       compressor_on;
    logic [8:0] compressor_freq;
    logic       evap_fan_on;
    logic       cond_fan_on;
    logic       valve_move;
    logic       fan_delay_restart;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/dcs_cfg_regs.sv */
// Configuration register file of the defrost cycle sequencer.
// Depends on dcs_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module dcs_cfg_regs
  import dcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  output cfg_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.defrost_interval    <= 17'd10800;
      cfg.min_interval        <= 17'd7200;
      cfg.heat_max_time       <= 12'd300;
      cfg.drip_time           <= 12'd300;
      cfg.heat_temp_limit     <= 11'sd100;
      cfg.temp_diff_threshold <= 10'd150;
      cfg.step_delay          <= 10'd30;
      cfg.comp_wait           <= 10'd15;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEFROST_INTERVAL: cfg.defrost_interval    <= cfg_data;
        REG_MIN_INTERVAL:     cfg.min_interval        <= cfg_data;
        REG_HEAT_MAX_TIME:    cfg.heat_max_time       <= cfg_data[11:0];
        REG_DRIP_TIME:        cfg.drip_time           <= cfg_data[11:0];
        REG_HEAT_TEMP_LIMIT:  cfg.heat_temp_limit     <= $signed(cfg_data[10:0]);
        REG_TEMP_DIFF_THRESH: cfg.temp_diff_threshold <= cfg_data[9:0];
        REG_STEP_DELAY:       cfg.step_delay          <= cfg_data[9:0];
        REG_COMP_WAIT:        cfg.comp_wait           <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dcs_heat_seq.sv */
// Next-state logic of the heating sub-sequence: settle delays, valve move,
// compressor delay and frequency ramp. Depends on dcs_pkg.
`default_nettype none

module dcs_heat_seq
  import dcs_pkg::*;
#(
  parameter int FREQ_MIN  = 20,
  parameter int FREQ_MAX  = 320,
  parameter int FREQ_STEP = 10
) (
  input  wire heat_t       hs,
  input  wire logic [9:0]  step_delay,
  input  wire logic [9:0]  comp_wait,
  output heat_t            hs_out,
  output logic             comp_set,
  output logic             dur_clear,
  output logic             valve_pulse
);

  logic [9:0] step_inc;
  logic [9:0] ramp_sum;

  assign step_inc = (hs.step_count == 10'h3FF) ? hs.step_count : hs.step_count + 10'd1;
  assign ramp_sum = {1'b0, hs.ramp_freq} + 10'(FREQ_STEP);

  always_comb begin
    hs_out      = hs;
    comp_set    = 1'b0;
    dur_clear   = 1'b0;
    valve_pulse = 1'b0;
    case (hs.substep)
      HS_IDLE: begin
        hs_out.step_count = '0;
        hs_out.substep    = HS_DELAY1;
      end
      HS_DELAY1: begin
        hs_out.step_count = step_inc;
        if (step_inc >= step_delay) begin
          hs_out.substep = HS_VALVE;
        end
      end
      HS_VALVE: begin
        valve_pulse       = 1'b1;
        hs_out.step_count = '0;
        hs_out.substep    = HS_DELAY2;
      end
      HS_DELAY2: begin
        hs_out.step_count = step_inc;
        if (step_inc >= step_delay) begin
          hs_out.step_count = '0;
          hs_out.substep    = HS_COMP;
        end
      end
      HS_COMP: begin
        hs_out.step_count = step_inc;
        if (step_inc >= comp_wait) begin
          hs_out.ramp_freq  = 9'(FREQ_MIN);
          hs_out.step_count = '0;
          hs_out.substep    = HS_RAMP;
          comp_set          = 1'b1;
        end
      end
      HS_RAMP: begin
        if (ramp_sum >= 10'(FREQ_MAX)) begin
          hs_out.ramp_freq = 9'(FREQ_MAX);
          hs_out.substep   = HS_RUN;
          dur_clear        = 1'b1;
        end else begin
          hs_out.ramp_freq = ramp_sum[8:0];
        end
      end
      HS_RUN: begin
      end
      default: begin
        hs_out = '{substep: HS_IDLE, step_count: '0, ramp_freq: '0};
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/dcs_core.sv */
// Phase state, elapsed-time counters and the per-tick decision logic of the
// defrost cycle sequencer. Depends on dcs_pkg and dcs_heat_seq.
`default_nettype none

module dcs_core
  import dcs_pkg::*;
#(
  parameter int FREQ_MIN  = 20,
  parameter int FREQ_MAX  = 320,
  parameter int FREQ_STEP = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step_en,
  input  wire logic [10:0] evap_temp,
  input  wire logic [10:0] cabinet_temp,
  input  wire logic        manual_key,
  input  wire cfg_t        cfg,
  output res_t             res
);

  logic [1:0]  ph;
  heat_t       hs;
  logic [16:0] ic;
  logic [11:0] dc;
  logic [11:0] drc;
  lat_t        lat;

  logic [1:0]  ph_next;
  heat_t       hs_next;
  logic [16:0] ic_next;
  logic [11:0] dc_next;
  logic [11:0] drc_next;
  lat_t        lat_next;
  logic        pulse_valve;
  logic        pulse_fan;

  heat_t       hs_seq;
  logic        comp_set;
  logic        dur_clear;
  logic        valve_pulse;

  logic               standby;
  logic [16:0]        ic_inc;
  logic [11:0]        dc_inc;
  logic [11:0]        drc_inc;
  logic signed [10:0] evap_s;
  logic signed [10:0] limit_s;
  logic signed [11:0] diff;
  logic               start_cond;
  logic               dur_done;

  localparam heat_t HEAT_CLEAR = '{substep: HS_IDLE, step_count: '0, ramp_freq: '0};

  dcs_heat_seq #(
    .FREQ_MIN  (FREQ_MIN),
    .FREQ_MAX  (FREQ_MAX),
    .FREQ_STEP (FREQ_STEP)
  ) u_heat_seq (
    .hs          (hs),
    .step_delay  (cfg.step_delay),
    .comp_wait   (cfg.comp_wait),
    .hs_out      (hs_seq),
    .comp_set    (comp_set),
    .dur_clear   (dur_clear),
    .valve_pulse (valve_pulse)
  );

  assign standby = (ph != PH_HEAT) && (ph != PH_DRIP);
  assign ic_inc  = (standby && ic != 17'h1FFFF) ? ic + 17'd1 : ic;
  assign dc_inc  = (ph == PH_HEAT && dc != 12'hFFF) ? dc + 12'd1 : dc;
  assign drc_inc = (ph == PH_DRIP && drc != 12'hFFF) ? drc + 12'd1 : drc;

  assign evap_s  = $signed(evap_temp);
  assign limit_s = cfg.heat_temp_limit;
  assign diff    = $signed({cabinet_temp[10], cabinet_temp}) - $signed({evap_temp[10], evap_temp});

  assign start_cond = (ic_inc >= cfg.defrost_interval) ||
                      ((ic_inc >= cfg.min_interval) &&
                       (diff > $signed({2'b00, cfg.temp_diff_threshold})));
  assign dur_done   = dc_inc >= cfg.heat_max_time;

  always_comb begin
    ph_next     = ph;
    hs_next     = hs;
    ic_next     = ic_inc;
    dc_next     = dc_inc;
    drc_next    = drc_inc;
    lat_next    = lat;
    pulse_valve = 1'b0;
    pulse_fan   = 1'b0;
    if (manual_key && !standby) begin
      hs_next  = HEAT_CLEAR;
      lat_next = '{heater: 1'b0, comp: 1'b0, evap_fan: 1'b1, cond_fan: 1'b1};
      ic_next  = '0;
      dc_next  = '0;
      drc_next = '0;
      ph_next  = PH_STANDBY;
    end else if (manual_key || (standby && start_cond)) begin
      ph_next  = PH_HEAT;
      dc_next  = '0;
      lat_next = '{heater: 1'b1, comp: 1'b0, evap_fan: 1'b0, cond_fan: 1'b0};
      hs_next  = '{substep: HS_DELAY1, step_count: '0, ramp_freq: '0};
    end else if (ph == PH_HEAT) begin
      hs_next     = hs_seq;
      pulse_valve = valve_pulse;
      if (comp_set) begin
        lat_next.comp = 1'b1;
      end
      if (dur_clear) begin
        dc_next = '0;
      end
      if (dur_done || evap_s >= limit_s) begin
        lat_next.heater = 1'b0;
        lat_next.comp   = 1'b0;
        hs_next         = HEAT_CLEAR;
        ph_next         = PH_DRIP;
        drc_next        = '0;
        dc_next         = '0;
      end
    end else if (ph == PH_DRIP) begin
      if (drc_inc >= cfg.drip_time) begin
        ph_next   = PH_STANDBY;
        drc_next  = '0;
        ic_next   = '0;
        hs_next   = HEAT_CLEAR;
        pulse_fan = 1'b1;
      end
    end
  end

  always_comb begin
    res.phase             = ph_next;
    res.heat_step         = hs_next.substep;
    res.heater_on         = lat_next.heater;
    res.compressor_on     = lat_next.comp;
    res.compressor_freq   = lat_next.comp ? hs_next.ramp_freq : 9'd0;
    res.evap_fan_on       = lat_next.evap_fan;
    res.cond_fan_on       = lat_next.cond_fan;
    res.valve_move        = pulse_valve;
    res.fan_delay_restart = pulse_fan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph  <= PH_STANDBY;
      hs  <= HEAT_CLEAR;
      ic  <= '0;
      dc  <= '0;
      drc <= '0;
      lat <= '{heater: 1'b0, comp: 1'b0, evap_fan: 1'b1, cond_fan: 1'b1};
    end else if (step_en) begin
      ph  <= ph_next;
      hs  <= hs_next;
      ic  <= ic_next;
      dc  <= dc_next;
      drc <= drc_next;
      lat <= lat_next;
    end
  end

  a_substep_only_heating: assert property (@(posedge clk) disable iff (rst)
    (hs.substep != HS_IDLE) |-> (ph == PH_HEAT))
    else $error("heating sub-step active outside the heating phase");

  a_heater_iff_heating: assert property (@(posedge clk) disable iff (rst)
    lat.heater == (ph == PH_HEAT))
    else $error("heater relay disagrees with the phase");

  a_comp_after_delay: assert property (@(posedge clk) disable iff (rst)
    lat.comp |-> (ph == PH_HEAT && (hs.substep == HS_RAMP || hs.substep == HS_RUN)))
    else $error("compressor on before the compressor delay has passed");

  a_fans_off_in_cycle: assert property (@(posedge clk) disable iff (rst)
    (ph == PH_HEAT) |-> (!lat.evap_fan && !lat.cond_fan))
    else $error("fan relay on during heating");

endmodule

`default_nettype wire

/* rtl/core/defrost_cycle_sequencer.sv */
// Top level of the defrost cycle sequencer: input register, result register,
// configuration registers and the core. Depends on dcs_pkg, dcs_cfg_regs, dcs_core.
`default_nettype none

// One request is taken per one-second tick and gives exactly one result. The
// block accepts a request in every clock cycle while the result is not stalled,
// as all the work for a request is one pass of logic between the input register
// and the result register, which presents the result until it is taken. A
// stalled result holds the core, and it stalls the request channel once the
// input register is also full.
// Configuration registers are written through the cfg port, which is always
// ready, and should be changed only while no request is in flight.

module defrost_cycle_sequencer
  import dcs_pkg::*;
#(
  parameter int FREQ_MIN  = 20,
  parameter int FREQ_MAX  = 320,
  parameter int FREQ_STEP = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [10:0] evap_temp,
  input  wire logic [10:0] cabinet_temp,
  input  wire logic        manual_key,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       phase,
  output logic [2:0]       heat_step,
  output logic             heater_on,
  output logic             compressor_on,
  output logic [8:0]       compressor_freq,
  output logic             evap_fan_on,
  output logic             cond_fan_on,
  output logic             valve_move,
  output logic             fan_delay_restart,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  cfg_t        cfg;
  res_t        res;
  res_t        res_reg;
  logic        s1_valid;
  logic [10:0] s1_evap;
  logic [10:0] s1_cab;
  logic        s1_key;
  logic        advance;
  logic        load;

  dcs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcs_core #(
    .FREQ_MIN  (FREQ_MIN),
    .FREQ_MAX  (FREQ_MAX),
    .FREQ_STEP (FREQ_STEP)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step_en      (advance),
    .evap_temp    (s1_evap),
    .cabinet_temp (s1_cab),
    .manual_key   (s1_key),
    .cfg          (cfg),
    .res          (res)
  );

  assign advance  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= load || (s1_valid && !advance);
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_evap <= evap_temp;
      s1_cab  <= cabinet_temp;
      s1_key  <= manual_key;
    end
    if (advance) begin
      res_reg <= res;
    end
  end

  assign phase             = res_reg.phase;
  assign heat_step         = res_reg.heat_step;
  assign heater_on         = res_reg.heater_on;
  assign compressor_on     = res_reg.compressor_on;
  assign compressor_freq   = res_reg.compressor_freq;
  assign evap_fan_on       = res_reg.evap_fan_on;
  assign cond_fan_on       = res_reg.cond_fan_on;
  assign valve_move        = res_reg.valve_move;
  assign fan_delay_restart = res_reg.fan_delay_restart;

endmodule

`default_nettype wire

/* tb/dcs_checker.sv */
// Checker for the defrost cycle sequencer: follows the register, request and
// result channels, predicts every result and compares it field by field.
// Depends on dcs_pkg.
`default_nettype none

module dcs_checker
  import dcs_pkg::*;
#(
  parameter int FREQ_MIN  = 20,
  parameter int FREQ_MAX  = 320,
  parameter int FREQ_STEP = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [10:0] evap_temp,
  input  wire logic [10:0] cabinet_temp,
  input  wire logic        manual_key,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  phase,
  input  wire logic [2:0]  heat_step,
  input  wire logic        heater_on,
  input  wire logic        compressor_on,
  input  wire logic [8:0]  compressor_freq,
  input  wire logic        evap_fan_on,
  input  wire logic        cond_fan_on,
  input  wire logic        valve_move,
  input  wire logic        fan_delay_restart,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  output int               mismatches,
  output int               outstanding,
  output int               checked,
  output int               valve_pulses,
  output int               drip_ends
);

  localparam lat_t FANS_ONLY = 4'b0011;

  cfg_t        regs;
  logic [1:0]  st_phase;
  logic [2:0]  st_step;
  logic [9:0]  st_count;
  logic [8:0]  st_freq;
  logic [16:0] st_interval;
  logic [11:0] st_duration;
  logic [11:0] st_drip;
  lat_t        st_lat;
  logic        valve_pulse;
  logic        fan_pulse;
  res_t        pending_results[$];

  function automatic int bump(int v, int top);
    return (v < top) ? v + 1 : top;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [8:0] got,
                             input logic [8:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d, %s: got %0d, expected %0d",
                                checked, name, got, want));
  endtask

  task automatic reset_controller();
    regs.defrost_interval    = 17'd10800;
    regs.min_interval        = 17'd7200;
    regs.heat_max_time       = 12'd300;
    regs.drip_time           = 12'd300;
    regs.heat_temp_limit     = 11'sd100;
    regs.temp_diff_threshold = 10'd150;
    regs.step_delay          = 10'd30;
    regs.comp_wait           = 10'd15;
    st_phase    = PH_STANDBY;
    st_step     = HS_IDLE;
    st_count    = '0;
    st_freq     = '0;
    st_interval = '0;
    st_duration = '0;
    st_drip     = '0;
    st_lat      = FANS_ONLY;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [16:0] data);
    case (idx)
      REG_DEFROST_INTERVAL: regs.defrost_interval    = data;
      REG_MIN_INTERVAL:     regs.min_interval        = data;
      REG_HEAT_MAX_TIME:    regs.heat_max_time       = data[11:0];
      REG_DRIP_TIME:        regs.drip_time           = data[11:0];
      REG_HEAT_TEMP_LIMIT:  regs.heat_temp_limit     = data[10:0];
      REG_TEMP_DIFF_THRESH: regs.temp_diff_threshold = data[9:0];
      REG_STEP_DELAY:       regs.step_delay          = data[9:0];
      REG_COMP_WAIT:        regs.comp_wait           = data[9:0];
      default: ;
    endcase
  endtask

  task automatic clear_heating();
    st_step  = HS_IDLE;
    st_count = '0;
    st_freq  = '0;
  endtask

  task automatic advance_heating();
    int f;
    case (st_step)
      HS_IDLE: begin
        st_count = '0;
        st_step  = HS_DELAY1;
      end
      HS_DELAY1: begin
        st_count = 10'(bump(int'(st_count), 1023));
        if (st_count >= regs.step_delay) st_step = HS_VALVE;
      end
      HS_VALVE: begin
        valve_pulse = 1'b1;
        st_count    = '0;
        st_step     = HS_DELAY2;
      end
      HS_DELAY2: begin
        st_count = 10'(bump(int'(st_count), 1023));
        if (st_count >= regs.step_delay) begin
          st_count = '0;
          st_step  = HS_COMP;
        end
      end
      HS_COMP: begin
        st_count = 10'(bump(int'(st_count), 1023));
        if (st_count >= regs.comp_wait) begin
          st_freq     = 9'(FREQ_MIN);
          st_lat.comp = 1'b1;
          st_count    = '0;
          st_step     = HS_RAMP;
        end
      end
      HS_RAMP: begin
        f = int'(st_freq) + FREQ_STEP;
        if (f >= FREQ_MAX) begin
          f           = FREQ_MAX;
          st_step     = HS_RUN;
          st_duration = '0;
        end
        st_freq = 9'(f);
      end
      HS_RUN: ;
      default: clear_heating();
    endcase
  endtask

  task automatic start_defrost();
    st_phase    = PH_HEAT;
    st_duration = '0;
    st_lat      = '0;
    st_lat.heater = 1'b1;
    clear_heating();
    advance_heating();
  endtask

  task automatic step_controller(input logic signed [10:0] evap,
                                 input logic signed [10:0] cab,
                                 input logic key, output res_t r);
    logic timed_out;
    valve_pulse = 1'b0;
    fan_pulse   = 1'b0;
    if (st_phase == PH_HEAT) st_duration = 12'(bump(int'(st_duration), 4095));
    else if (st_phase == PH_DRIP) st_drip = 12'(bump(int'(st_drip), 4095));
    else st_interval = 17'(bump(int'(st_interval), 131071));

    if (key && (st_phase == PH_HEAT || st_phase == PH_DRIP)) begin
      clear_heating();
      st_lat      = FANS_ONLY;
      st_interval = '0;
      st_duration = '0;
      st_drip     = '0;
      st_phase    = PH_STANDBY;
    end else if (key) begin
      start_defrost();
    end else if (st_phase == PH_HEAT) begin
      timed_out = st_duration >= regs.heat_max_time;
      advance_heating();
      if (timed_out || int'(evap) >= int'($signed(regs.heat_temp_limit))) begin
        st_lat.heater = 1'b0;
        st_lat.comp   = 1'b0;
        clear_heating();
        st_phase    = PH_DRIP;
        st_drip     = '0;
        st_duration = '0;
      end
    end else if (st_phase == PH_DRIP) begin
      if (st_drip >= regs.drip_time) begin
        st_phase    = PH_STANDBY;
        st_drip     = '0;
        st_interval = '0;
        clear_heating();
        fan_pulse = 1'b1;
      end
    end else begin
      if (st_interval >= regs.defrost_interval)
        start_defrost();
      else if (st_interval >= regs.min_interval &&
               int'(cab) - int'(evap) > int'(regs.temp_diff_threshold))
        start_defrost();
    end

    r.phase             = st_phase;
    r.heat_step         = st_step;
    r.heater_on         = st_lat.heater;
    r.compressor_on     = st_lat.comp;
    r.compressor_freq   = st_lat.comp ? st_freq : 9'd0;
    r.evap_fan_on       = st_lat.evap_fan;
    r.cond_fan_on       = st_lat.cond_fan;
    r.valve_move        = valve_pulse;
    r.fan_delay_restart = fan_pulse;
  endtask

  always @(posedge clk) begin : watch
    res_t seen;
    res_t want;
    if (rst) begin
      reset_controller();
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.phase             = phase;
        seen.heat_step         = heat_step;
        seen.heater_on         = heater_on;
        seen.compressor_on     = compressor_on;
        seen.compressor_freq   = compressor_freq;
        seen.evap_fan_on       = evap_fan_on;
        seen.cond_fan_on       = cond_fan_on;
        seen.valve_move        = valve_move;
        seen.fan_delay_restart = fan_delay_restart;
        checked++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request waiting",
                                    checked));
        end else begin
          want = pending_results.pop_front();
          if (want.valve_move) valve_pulses++;
          if (want.fan_delay_restart) drip_ends++;
          check_field("phase", 9'(seen.phase), 9'(want.phase));
          check_field("heat_step", 9'(seen.heat_step), 9'(want.heat_step));
          check_field("heater_on", 9'(seen.heater_on), 9'(want.heater_on));
          check_field("compressor_on", 9'(seen.compressor_on),
                      9'(want.compressor_on));
          check_field("compressor_freq", seen.compressor_freq, want.compressor_freq);
          check_field("evap_fan_on", 9'(seen.evap_fan_on), 9'(want.evap_fan_on));
          check_field("cond_fan_on", 9'(seen.cond_fan_on), 9'(want.cond_fan_on));
          check_field("valve_move", 9'(seen.valve_move), 9'(want.valve_move));
          check_field("fan_delay_restart", 9'(seen.fan_delay_restart),
                      9'(want.fan_delay_restart));
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        step_controller(evap_temp, cabinet_temp, manual_key, want);
        pending_results.push_back(want);
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

`default_nettype wire

/* tb/tb_defrost_cycle_sequencer.sv */
// Testbench top for the defrost cycle sequencer: clock, reset, register
// programming and tick requests with random idling on both channels.
// Depends on dcs_pkg, defrost_cycle_sequencer and dcs_checker.
`default_nettype none

module tb_defrost_cycle_sequencer
  import dcs_pkg::*;
();

  localparam int TICK_TARGET = 1400;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic [10:0] evap_temp    = '0;
  logic [10:0] cabinet_temp = '0;
  logic        manual_key   = 1'b0;
  logic        out_stall    = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [2:0]  cfg_index    = '0;
  logic [16:0] cfg_data     = '0;
  logic        in_stall;
  logic        out_valid;
  logic        cfg_ready;
  logic [1:0]  phase;
  logic [2:0]  heat_step;
  logic        heater_on;
  logic        compressor_on;
  logic [8:0]  compressor_freq;
  logic        evap_fan_on;
  logic        cond_fan_on;
  logic        valve_move;
  logic        fan_delay_restart;

  int mismatches;
  int outstanding;
  int checked;
  int valve_pulses;
  int drip_ends;

  int sent          = 0;
  int settings_used = 0;
  int gap_pct       = 0;
  int stall_pct     = 0;

  defrost_cycle_sequencer u_dut (.*);
  dcs_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results still expected.", outstanding);
    $display("Mismatches found");
    $finish;
  end

  initial begin : receiver_stalls
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int pick_rate();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 25;
      default: return 60;
    endcase
  endfunction

  function automatic cfg_t settings_of(int ival, int mval, int hmax, int drip,
                                       int lim, int thr, int sd, int cd);
    cfg_t c;
    c.defrost_interval    = 17'(ival);
    c.min_interval        = 17'(mval);
    c.heat_max_time       = 12'(hmax);
    c.drip_time           = 12'(drip);
    c.heat_temp_limit     = 11'(lim);
    c.temp_diff_threshold = 10'(thr);
    c.step_delay          = 10'(sd);
    c.comp_wait           = 10'(cd);
    return c;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(REG_DEFROST_INTERVAL, c.defrost_interval);
    write_reg(REG_MIN_INTERVAL, c.min_interval);
    write_reg(REG_HEAT_MAX_TIME, 17'(c.heat_max_time));
    write_reg(REG_DRIP_TIME, 17'(c.drip_time));
    write_reg(REG_HEAT_TEMP_LIMIT, {{6{c.heat_temp_limit[10]}}, c.heat_temp_limit});
    write_reg(REG_TEMP_DIFF_THRESH, 17'(c.temp_diff_threshold));
    write_reg(REG_STEP_DELAY, 17'(c.step_delay));
    write_reg(REG_COMP_WAIT, 17'(c.comp_wait));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_tick(input logic signed [10:0] ev, input logic signed [10:0] cb,
                           input logic key);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    evap_temp    <= ev;
    cabinet_temp <= cb;
    manual_key   <= key;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Mostly evaporator readings below the heating limit, so that heating runs
  // through its sub-sequence, with occasional readings anywhere in range.
  task automatic random_tick(input cfg_t c, input int key_pct);
    int lim;
    int ev;
    int cb;
    lim = int'($signed(c.heat_temp_limit));
    if (lim > -500 && $urandom_range(0, 99) < 90)
      ev = -500 + int'($urandom_range(0, lim + 499));
    else
      ev = int'($urandom_range(0, 1500)) - 500;
    cb = int'($urandom_range(0, 1500)) - 500;
    send_tick(11'(ev), 11'(cb), $urandom_range(0, 99) < key_pct);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    cfg_t c;
    int   round;
    int   sel;
    int   n;
    int   key_pct;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct   = 25;
    stall_pct = 25;
    // Reset settings: difference without minimum interval, manual start,
    // temperature end of heating, cancel in drip and in heating.
    send_tick(0, 0, 1'b0);
    send_tick(-500, 1000, 1'b0);
    send_tick(1000, -500, 1'b0);
    send_tick(0, 0, 1'b1);
    send_tick(0, 0, 1'b0);
    send_tick(1000, 0, 1'b0);
    send_tick(0, 0, 1'b0);
    send_tick(0, 0, 1'b1);
    send_tick(0, 0, 1'b1);
    send_tick(0, 0, 1'b1);
    send_tick(100, 0, 1'b0);
    drain();

    // Short delays: early defrost by difference, the whole heating sequence
    // into the ramp, temperature limit and a normal drip end.
    program_regs(settings_of(86400, 0, 3600, 1, 1000, 0, 1, 1));
    send_tick(0, 0, 1'b0);
    send_tick(-500, -499, 1'b0);
    repeat (5) send_tick(0, 0, 1'b0);
    send_tick(999, 0, 1'b0);
    send_tick(1000, 0, 1'b0);
    send_tick(0, 0, 1'b0);
    drain();

    round = 0;
    while (sent < TICK_TARGET) begin
      sel = (round < 2) ? round : $urandom_range(0, 5);
      case (sel)
        0: c = settings_of(1, 0, 1, 1, -500, 0, 1, 1);
        1: c = settings_of(86400, 86400, 3600, 3600, 1000, 1000, 600, 600);
        default: c = settings_of($urandom_range(1, 60), $urandom_range(0, 40),
                                 $urandom_range(1, 90), $urandom_range(1, 20),
                                 int'($urandom_range(0, 1500)) - 500,
                                 $urandom_range(0, 1000), $urandom_range(1, 8),
                                 $urandom_range(1, 8));
      endcase
      key_pct = (sel == 1) ? 8 : 2;
      n = (sel <= 1) ? 40 : $urandom_range(80, 160);
      if (sent >= TICK_TARGET - 250) begin
        gap_pct   = 0;
        stall_pct = 0;
        while (out_stall) @(posedge clk);
      end else begin
        gap_pct   = pick_rate();
        stall_pct = pick_rate();
      end
      program_regs(c);
      repeat (n) random_tick(c, key_pct);
      drain();
      round++;
    end

    $display("Sent %0d tick requests under %0d register settings, %0d results compared.",
             sent, settings_used, checked);
    $display("Valve steps predicted: %0d; drips ended normally: %0d.",
             valve_pulses, drip_ends);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
